@@ rtl/cgds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgds_pkg: shared types and constants
// Sizes, codes and job descriptor for the chunk grant and donor select block.
// ----------------------------------------------------------------------------
package cgds_pkg;

    // Sizing
    localparam int MAX_WORKERS = 16;
    localparam int MAX_CHUNKS  = 65536;
    localparam int COUNT_WIDTH = 32;

    localparam int IDX_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int NF_W   = $clog2(MAX_CHUNKS) + 1;

    // Field widths
    localparam int OP_W        = 2;
    localparam int WID_W       = 4;
    localparam int DEC_W       = 2;
    localparam int CHUNK_IDX_W = 16;
    localparam int RATE_W      = 7;
    localparam int KW          = $clog2(RATE_W);
    localparam int NUM_W       = COUNT_WIDTH + RATE_W;
    localparam int CMP_W       = (IDX_W > WID_W) ? IDX_W : WID_W;

    // Configuration registers
    localparam int CT_W       = 17;
    localparam int WC_W       = 5;
    localparam int SL_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_TOTAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT = 2'd2;

    localparam logic [CT_W-1:0] CT_RESET = 17'd65536;
    localparam logic [WC_W-1:0] WC_RESET = 5'd16;
    localparam logic [SL_W-1:0] SL_RESET = 7'd5;

    // Opcodes
    localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_W-1:0] OP_VISIT   = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd2;

    // Decisions
    localparam logic [DEC_W-1:0] DEC_GRANT = 2'd0;
    localparam logic [DEC_W-1:0] DEC_SELF  = 2'd1;
    localparam logic [DEC_W-1:0] DEC_DONOR = 2'd2;
    localparam logic [DEC_W-1:0] DEC_EVENT = 2'd3;

    // Rates
    localparam logic [RATE_W-1:0] PERCENT   = 7'd100;
    localparam logic [RATE_W-1:0] RATE_NONE = 7'd101;

    // Job queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        K_GRANT,
        K_SCAN,
        K_VISIT,
        K_TICK,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [CHUNK_IDX_W-1:0] chunk_index;
        logic [WID_W-1:0]       worker_id;
        logic                   was_miss;
    } t_job;

    typedef struct packed {
        logic [WC_W-1:0] worker_count;
        logic [SL_W-1:0] spread_limit;
    } t_scan_cfg;

endpackage

@@ rtl/cgds_item_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgds_item_if: request / event channel
// Valid-ready channel carrying one input item.
// ----------------------------------------------------------------------------
interface cgds_item_if;
    logic                        valid;
    logic                        ready;
    logic [cgds_pkg::OP_W-1:0]   opcode;
    logic [cgds_pkg::WID_W-1:0]  worker_id;
    logic                        was_miss;

    modport source (output valid, output opcode, output worker_id, output was_miss,
                    input ready);
    modport sink   (input valid, input opcode, input worker_id, input was_miss,
                    output ready);
endinterface

@@ rtl/cgds_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgds_result_if: result channel
// Valid-ready channel carrying one grant or eviction decision.
// ----------------------------------------------------------------------------
interface cgds_result_if;
    logic                              valid;
    logic                              ready;
    logic [cgds_pkg::DEC_W-1:0]        decision;
    logic [cgds_pkg::CHUNK_IDX_W-1:0]  chunk_index;
    logic [cgds_pkg::WID_W-1:0]        donor_id;
    logic [cgds_pkg::RATE_W-1:0]       donor_hit_rate;

    modport source (output valid, output decision, output chunk_index, output donor_id,
                    output donor_hit_rate, input ready);
    modport sink   (input valid, input decision, input chunk_index, input donor_id,
                    input donor_hit_rate, output ready);
endinterface

@@ rtl/cgds_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgds_cfg_if: configuration write channel
// Valid-ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface cgds_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cgds_pkg::CFG_IDX_W-1:0]    index;
    logic [cgds_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/cgds_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgds_front: intake and classification
// Takes items, owns the bump pointer, grants fresh chunks and queues jobs.
// ----------------------------------------------------------------------------
module cgds_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cgds_item_if.sink                    i_item,
    input  logic [cgds_pkg::CT_W-1:0]    i_chunk_total,
    input  logic                         i_q_full,
    output logic                         o_push,
    output cgds_pkg::t_job               o_push_job
);

    logic [cgds_pkg::NF_W-1:0] r_next_free;
    logic [cgds_pkg::NF_W-1:0] n_next_free;
    logic [31:0]               limit;
    logic                      has_chunk;
    logic                      accept;

    assign i_item.ready = !i_q_full;
    assign accept       = i_item.valid && i_item.ready;
    assign o_push       = accept;

    // Totals above the chunk pool size act as the pool size
    assign limit = (32'(i_chunk_total) > 32'(cgds_pkg::MAX_CHUNKS)) ?
                   32'(cgds_pkg::MAX_CHUNKS) : 32'(i_chunk_total);
    assign has_chunk = 32'(r_next_free) < limit;

    always_comb begin
        o_push_job.chunk_index = '0;
        o_push_job.worker_id   = i_item.worker_id;
        o_push_job.was_miss    = i_item.was_miss;
        n_next_free            = r_next_free;
        case (i_item.opcode)
            cgds_pkg::OP_REQUEST: begin
                if (has_chunk) begin
                    o_push_job.kind        = cgds_pkg::K_GRANT;
                    o_push_job.chunk_index = cgds_pkg::CHUNK_IDX_W'(r_next_free);
                    if (accept) begin
                        n_next_free = cgds_pkg::NF_W'(r_next_free + 1'b1);
                    end
                end else begin
                    o_push_job.kind = cgds_pkg::K_SCAN;
                end
            end
            cgds_pkg::OP_VISIT: o_push_job.kind = cgds_pkg::K_VISIT;
            cgds_pkg::OP_TICK:  o_push_job.kind = cgds_pkg::K_TICK;
            default:            o_push_job.kind = cgds_pkg::K_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= '0;
        end else begin
            r_next_free <= n_next_free;
        end
    end

endmodule

@@ rtl/cgds_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgds_queue: job queue
// Short FIFO that decouples the intake from the executing back end.
// ----------------------------------------------------------------------------
module cgds_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cgds_pkg::t_job  i_push_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cgds_pkg::t_job  o_job
);

    cgds_pkg::t_job                r_slot [cgds_pkg::QUEUE_DEPTH];
    logic [cgds_pkg::QPTR_W-1:0]   r_wr;
    logic [cgds_pkg::QPTR_W-1:0]   r_rd;
    logic [cgds_pkg::QCNT_W-1:0]   r_count;
    logic [cgds_pkg::QPTR_W-1:0]   n_wr;
    logic [cgds_pkg::QPTR_W-1:0]   n_rd;
    logic [cgds_pkg::QCNT_W-1:0]   n_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = r_count == cgds_pkg::QCNT_W'(cgds_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == cgds_pkg::QPTR_W'(cgds_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : cgds_pkg::QPTR_W'(r_wr + 1'b1);
        end
        if (do_pop) begin
            n_rd = (r_rd == cgds_pkg::QPTR_W'(cgds_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : cgds_pkg::QPTR_W'(r_rd + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_count = cgds_pkg::QCNT_W'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = cgds_pkg::QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/cgds_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgds_back: job execution
// Holds the per-worker counters, runs the hit-rate scan and drives results.
// ----------------------------------------------------------------------------
module cgds_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    input  cgds_pkg::t_job         i_job,
    output logic                   o_pop,
    input  cgds_pkg::t_scan_cfg    i_cfg,
    cgds_result_if.source          o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_CMP
    } t_state;

    function automatic logic [cgds_pkg::COUNT_WIDTH-1:0] sat_inc(
        input logic [cgds_pkg::COUNT_WIDTH-1:0] v
    );
        return (&v) ? v : cgds_pkg::COUNT_WIDTH'(v + 1'b1);
    endfunction

    t_state                              r_state,  n_state;
    logic [cgds_pkg::COUNT_WIDTH-1:0]    r_visit [cgds_pkg::MAX_WORKERS];
    logic [cgds_pkg::COUNT_WIDTH-1:0]    n_visit [cgds_pkg::MAX_WORKERS];
    logic [cgds_pkg::COUNT_WIDTH-1:0]    r_miss  [cgds_pkg::MAX_WORKERS];
    logic [cgds_pkg::COUNT_WIDTH-1:0]    n_miss  [cgds_pkg::MAX_WORKERS];
    logic [cgds_pkg::IDX_W-1:0]          r_idx,    n_idx;
    logic [cgds_pkg::IDX_W-1:0]          r_last,   n_last;
    logic [cgds_pkg::WID_W-1:0]          r_wid,    n_wid;
    logic [cgds_pkg::NUM_W-1:0]          r_num,    n_num;
    logic [cgds_pkg::COUNT_WIDTH-1:0]    r_den,    n_den;
    logic [cgds_pkg::KW-1:0]             r_k,      n_k;
    logic [cgds_pkg::RATE_W-1:0]         r_q,      n_q;
    logic [cgds_pkg::RATE_W-1:0]         r_lo,     n_lo;
    logic [cgds_pkg::RATE_W-1:0]         r_hi,     n_hi;
    logic [cgds_pkg::IDX_W-1:0]          r_hi_idx, n_hi_idx;
    logic                                r_out_valid, n_out_valid;
    logic [cgds_pkg::DEC_W-1:0]          r_out_dec,   n_out_dec;
    logic [cgds_pkg::CHUNK_IDX_W-1:0]    r_out_chunk, n_out_chunk;
    logic [cgds_pkg::WID_W-1:0]          r_out_donor, n_out_donor;
    logic [cgds_pkg::RATE_W-1:0]         r_out_rate,  n_out_rate;

    logic [cgds_pkg::IDX_W-1:0]          rd_idx;
    logic [cgds_pkg::COUNT_WIDTH-1:0]    rd_visit;
    logic [cgds_pkg::COUNT_WIDTH-1:0]    rd_miss;
    logic                                wid_ok;
    logic                                can_pop;
    logic [cgds_pkg::NUM_W-1:0]          shifted;
    logic [cgds_pkg::IDX_W-1:0]          nw_last;
    logic [cgds_pkg::RATE_W-1:0]         c_lo;
    logic [cgds_pkg::RATE_W-1:0]         c_hi;
    logic [cgds_pkg::IDX_W-1:0]          c_hi_idx;
    logic [cgds_pkg::RATE_W-1:0]         spread;
    logic                                self_evict;

    // One counter read port, shared by visit updates and the scan
    assign rd_idx   = (r_state == S_IDLE) ? cgds_pkg::IDX_W'(i_job.worker_id) : r_idx;
    assign rd_visit = r_visit[rd_idx];
    assign rd_miss  = r_miss[rd_idx];
    assign wid_ok   = 32'(i_job.worker_id) < 32'(cgds_pkg::MAX_WORKERS);
    assign can_pop  = (r_state == S_IDLE) && i_job_valid && (!r_out_valid || o_result.ready);
    assign o_pop    = can_pop;

    assign shifted  = cgds_pkg::NUM_W'(r_den) << r_k;

    // Worker count of zero acts as one, above the array size as the size
    always_comb begin
        if (i_cfg.worker_count == '0) begin
            nw_last = '0;
        end else if (32'(i_cfg.worker_count) > 32'(cgds_pkg::MAX_WORKERS)) begin
            nw_last = cgds_pkg::IDX_W'(cgds_pkg::MAX_WORKERS - 1);
        end else begin
            nw_last = cgds_pkg::IDX_W'(i_cfg.worker_count - 1'b1);
        end
    end

    // Running min / max including the worker just measured; first index wins ties
    assign c_lo       = (r_q < r_lo) ? r_q : r_lo;
    assign c_hi       = (r_q > r_hi) ? r_q : r_hi;
    assign c_hi_idx   = (r_q > r_hi) ? r_idx : r_hi_idx;
    assign spread     = c_hi - c_lo;
    assign self_evict = (spread <= i_cfg.spread_limit) ||
                        (cgds_pkg::CMP_W'(c_hi_idx) == cgds_pkg::CMP_W'(r_wid));

    always_comb begin
        n_state     = r_state;
        n_visit     = r_visit;
        n_miss      = r_miss;
        n_idx       = r_idx;
        n_last      = r_last;
        n_wid       = r_wid;
        n_num       = r_num;
        n_den       = r_den;
        n_k         = r_k;
        n_q         = r_q;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_hi_idx    = r_hi_idx;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_dec   = r_out_dec;
        n_out_chunk = r_out_chunk;
        n_out_donor = r_out_donor;
        n_out_rate  = r_out_rate;

        case (r_state)
            S_IDLE: begin
                if (can_pop) begin
                    n_out_dec   = cgds_pkg::DEC_EVENT;
                    n_out_chunk = '0;
                    n_out_donor = '0;
                    n_out_rate  = '0;
                    case (i_job.kind)
                        cgds_pkg::K_GRANT: begin
                            n_out_valid = 1'b1;
                            n_out_dec   = cgds_pkg::DEC_GRANT;
                            n_out_chunk = i_job.chunk_index;
                        end
                        cgds_pkg::K_VISIT: begin
                            n_out_valid = 1'b1;
                            if (wid_ok) begin
                                n_visit[rd_idx] = sat_inc(rd_visit);
                                if (i_job.was_miss) begin
                                    n_miss[rd_idx] = sat_inc(rd_miss);
                                end
                            end
                        end
                        cgds_pkg::K_TICK: begin
                            n_out_valid = 1'b1;
                            for (int w = 0; w < cgds_pkg::MAX_WORKERS; w++) begin
                                n_visit[w] = cgds_pkg::COUNT_WIDTH'(1);
                                n_miss[w]  = cgds_pkg::COUNT_WIDTH'(1);
                            end
                        end
                        cgds_pkg::K_SCAN: begin
                            n_idx    = '0;
                            n_last   = nw_last;
                            n_wid    = i_job.worker_id;
                            n_lo     = cgds_pkg::RATE_NONE;
                            n_hi     = '0;
                            n_hi_idx = '0;
                            n_state  = S_LOAD;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (rd_visit == '0 || rd_miss > rd_visit) begin
                    n_q     = '0;
                    n_state = S_CMP;
                end else begin
                    n_num   = cgds_pkg::NUM_W'(rd_visit - rd_miss) *
                              cgds_pkg::NUM_W'(cgds_pkg::PERCENT);
                    n_den   = rd_visit;
                    n_k     = cgds_pkg::KW'(cgds_pkg::RATE_W - 1);
                    n_q     = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // Restoring division, one quotient bit a cycle; quotient stays below 128
                if (r_num >= shifted) begin
                    n_num    = r_num - shifted;
                    n_q[r_k] = 1'b1;
                end
                if (r_k == '0) begin
                    n_state = S_CMP;
                end else begin
                    n_k = cgds_pkg::KW'(r_k - 1'b1);
                end
            end
            S_CMP: begin
                n_lo     = c_lo;
                n_hi     = c_hi;
                n_hi_idx = c_hi_idx;
                if (r_idx == r_last) begin
                    n_out_valid = 1'b1;
                    n_out_chunk = '0;
                    n_out_rate  = c_hi;
                    if (self_evict) begin
                        n_out_dec   = cgds_pkg::DEC_SELF;
                        n_out_donor = r_wid;
                    end else begin
                        n_out_dec   = cgds_pkg::DEC_DONOR;
                        n_out_donor = cgds_pkg::WID_W'(c_hi_idx);
                    end
                    n_state = S_IDLE;
                end else begin
                    n_idx   = cgds_pkg::IDX_W'(r_idx + 1'b1);
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int w = 0; w < cgds_pkg::MAX_WORKERS; w++) begin
                r_visit[w] <= '0;
                r_miss[w]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_visit     <= n_visit;
            r_miss      <= n_miss;
            r_idx       <= n_idx;
            r_last      <= n_last;
            r_wid       <= n_wid;
            r_num       <= n_num;
            r_den       <= n_den;
            r_k         <= n_k;
            r_q         <= n_q;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_hi_idx    <= n_hi_idx;
            r_out_dec   <= n_out_dec;
            r_out_chunk <= n_out_chunk;
            r_out_donor <= n_out_donor;
            r_out_rate  <= n_out_rate;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.decision       = r_out_dec;
    assign o_result.chunk_index    = r_out_chunk;
    assign o_result.donor_id       = r_out_donor;
    assign o_result.donor_hit_rate = r_out_rate;

    // Divider never yields a percentage above 100
    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_q <= cgds_pkg::PERCENT))
        else $error("hit rate above 100");

    // Scan result lands in an empty output register
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && r_idx == r_last) |-> !r_out_valid)
        else $error("scan result would overwrite pending result");

    // A queued grant is presented on the next cycle
    a_grant_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (can_pop && i_job.kind == cgds_pkg::K_GRANT) |=>
        (r_out_valid && r_out_dec == cgds_pkg::DEC_GRANT))
        else $error("grant not presented");

endmodule

@@ rtl/chunk_grant_and_donor_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_grant_and_donor_select: chunk grant and donor selection
// Hands out fresh cache chunks and, once exhausted, picks an evicting worker.
// ----------------------------------------------------------------------------
// Usage
//   i_item   : requests (opcode 0), visit events (1) and statistics ticks (2).
//   o_result : one result per item, in item order.
//   i_cfg    : register writes (0 chunk_total, 1 worker_count, 2 spread_limit);
//              always ready, write only while the block is idle.
// Throughput
//   Grants, visits, ticks: each passes through the job queue into the result
//   register; one item per cycle sustained while o_result.ready stays high and no scan runs.
//   Request after exhaustion: the back end scans the active workers one at a
//   time through a shared 7-step restoring divider; each worker takes a load
//   step, the divider steps when its counts are usable, and a compare step.
//   The scan holds the back end; up to two further items may wait in the job
//   queue meanwhile.
// Reset
//   Synchronous, active low: bump pointer and all counters cleared, registers
//   back to 65536 / 16 / 5, queue and result register empty.
// Stall
//   A stalled result holds the back end; the queue then fills and i_item.ready
//   drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module chunk_grant_and_donor_select (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cgds_item_if.sink      i_item,
    cgds_result_if.source  o_result,
    cgds_cfg_if.sink       i_cfg
);

    // Configuration registers
    logic [cgds_pkg::CT_W-1:0]   r_chunk_total;
    logic [cgds_pkg::WC_W-1:0]   r_worker_count;
    logic [cgds_pkg::SL_W-1:0]   r_spread_limit;
    logic                        cfg_wr;

    // Front to queue
    logic                        push;
    cgds_pkg::t_job              push_job;
    logic                        q_full;

    // Queue to back
    logic                        job_valid;
    cgds_pkg::t_job              job;
    logic                        pop;
    cgds_pkg::t_scan_cfg         scan_cfg;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    // Writes to an index beyond the register list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_total  <= cgds_pkg::CT_RESET;
            r_worker_count <= cgds_pkg::WC_RESET;
            r_spread_limit <= cgds_pkg::SL_RESET;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                cgds_pkg::CFG_CHUNK_TOTAL:  r_chunk_total  <= i_cfg.data[cgds_pkg::CT_W-1:0];
                cgds_pkg::CFG_WORKER_COUNT: r_worker_count <= i_cfg.data[cgds_pkg::WC_W-1:0];
                cgds_pkg::CFG_SPREAD_LIMIT: r_spread_limit <= i_cfg.data[cgds_pkg::SL_W-1:0];
                default: ;
            endcase
        end
    end

    assign scan_cfg.worker_count = r_worker_count;
    assign scan_cfg.spread_limit = r_spread_limit;

    // Front: takes each transfer, grants from the bump pointer, classifies the rest
    cgds_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_item),
        .i_chunk_total (r_chunk_total),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_push_job    (push_job)
    );

    // Job queue between the two halves
    cgds_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_valid    (job_valid),
        .o_job      (job)
    );

    // Back: counter updates, hit-rate scan, result register
    cgds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .i_cfg       (scan_cfg),
        .o_result    (o_result)
    );

endmodule

@@ bench/grant_decision_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grant_decision_checker: predicts and checks grant / eviction decisions
// Watches the item, result and register channels, keeps its own copy of the
// bump pointer, hit counters and registers, and compares every result.
// ----------------------------------------------------------------------------
module grant_decision_checker
    import cgds_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    cgds_item_if    item_mon,
    cgds_result_if  result_mon,
    cgds_cfg_if     cfg_mon,
    output int      o_fail_count,
    output int      o_pending
);

    typedef struct packed {
        logic [DEC_W-1:0]       decision;
        logic [CHUNK_IDX_W-1:0] chunk_index;
        logic [WID_W-1:0]       donor_id;
        logic [RATE_W-1:0]      donor_hit_rate;
    } t_grant_outcome;

    // Mirrored registers and state
    logic [CT_W-1:0]        chunk_total;
    logic [WC_W-1:0]        worker_count;
    logic [SL_W-1:0]        spread_limit;
    logic [NF_W-1:0]        bump_ptr;
    logic [COUNT_WIDTH-1:0] visits [MAX_WORKERS];
    logic [COUNT_WIDTH-1:0] misses [MAX_WORKERS];

    t_grant_outcome outcome_q [$];
    int             fails;

    function automatic int unsigned hit_pct(input logic [COUNT_WIDTH-1:0] v,
                                            input logic [COUNT_WIDTH-1:0] m);
        longint unsigned hits;
        if (v == '0 || m > v)
            return 0;
        hits = longint'(v) - longint'(m);
        return int'((hits * 100) / longint'(v));
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_bump(input logic [COUNT_WIDTH-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Works out the decision for one item and advances the mirrored state.
    function automatic t_grant_outcome grant_outcome(input logic [OP_W-1:0]  op,
                                                     input logic [WID_W-1:0] wid,
                                                     input logic             miss);
        t_grant_outcome o;
        int unsigned    limit, n_scan, r, lo, hi, hi_idx;
        o = '{decision: DEC_EVENT, default: '0};
        case (op)
            OP_REQUEST: begin
                limit = (chunk_total > MAX_CHUNKS) ? MAX_CHUNKS : chunk_total;
                if (bump_ptr < limit) begin
                    o.decision    = DEC_GRANT;
                    o.chunk_index = bump_ptr[CHUNK_IDX_W-1:0];
                    bump_ptr      = bump_ptr + 1'b1;
                end else begin
                    n_scan = (worker_count == 0) ? 1 :
                             (worker_count > MAX_WORKERS) ? MAX_WORKERS : worker_count;
                    lo     = RATE_NONE;
                    hi     = 0;
                    hi_idx = 0;
                    for (int i = 0; i < n_scan; i++) begin
                        r = hit_pct(visits[i], misses[i]);
                        if (r < lo)
                            lo = r;
                        if (r > hi) begin
                            hi     = r;
                            hi_idx = i;
                        end
                    end
                    o.donor_hit_rate = RATE_W'(hi);
                    if (hi - lo <= spread_limit || hi_idx == wid) begin
                        o.decision = DEC_SELF;
                        o.donor_id = wid;
                    end else begin
                        o.decision = DEC_DONOR;
                        o.donor_id = WID_W'(hi_idx);
                    end
                end
            end
            OP_VISIT: begin
                if (wid < MAX_WORKERS) begin
                    visits[wid] = sat_bump(visits[wid]);
                    if (miss)
                        misses[wid] = sat_bump(misses[wid]);
                end
            end
            OP_TICK: begin
                for (int i = 0; i < MAX_WORKERS; i++) begin
                    visits[i] = 1;
                    misses[i] = 1;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_grant_outcome want;
        if (!i_rst_n) begin
            chunk_total  = CT_RESET;
            worker_count = WC_RESET;
            spread_limit = SL_RESET;
            bump_ptr     = '0;
            for (int i = 0; i < MAX_WORKERS; i++) begin
                visits[i] = '0;
                misses[i] = '0;
            end
            outcome_q.delete();
            fails = 0;
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (cfg_mon.index)
                    CFG_CHUNK_TOTAL:  chunk_total  = cfg_mon.data[CT_W-1:0];
                    CFG_WORKER_COUNT: worker_count = cfg_mon.data[WC_W-1:0];
                    CFG_SPREAD_LIMIT: spread_limit = cfg_mon.data[SL_W-1:0];
                    default: ;
                endcase
            end
            if (result_mon.valid && result_mon.ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result transfer with no outstanding item: decision %0d",
                           result_mon.decision);
                    fails++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("decision", want.decision, result_mon.decision);
                    check_field("chunk_index", want.chunk_index, result_mon.chunk_index);
                    check_field("donor_id", want.donor_id, result_mon.donor_id);
                    check_field("donor_hit_rate", want.donor_hit_rate,
                                result_mon.donor_hit_rate);
                end
            end
            if (item_mon.valid && item_mon.ready)
                outcome_q.push_back(grant_outcome(item_mon.opcode, item_mon.worker_id,
                                                  item_mon.was_miss));
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= fails;
    end

endmodule

@@ bench/tb_chunk_grant_and_donor_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chunk_grant_and_donor_select: top-level bench
// Drives requests, visits and ticks through the block under several register
// settings with random back-pressure; a side checker predicts each decision.
// ----------------------------------------------------------------------------
module tb_chunk_grant_and_donor_select;
    import cgds_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int END_SETTLE      = 200;      // longer than the longest scan
    localparam int CYCLE_LIMIT     = 1000000;

    // Opcode 3 has no meaning to the block; it should come back as a plain event
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cgds_item_if   item_ch ();
    cgds_result_if result_ch ();
    cgds_cfg_if    cfg_ch ();

    int fail_count;
    int pending;
    int cycle_count = 0;

    // Idle rates in percent, changed per phase
    int src_idle_pct = 34;
    int snk_idle_pct = 57;

    // Per-worker miss bias for the random part, so hit rates spread apart
    int unsigned miss_bias [MAX_WORKERS];

    // Run statistics for the summary
    int n_req = 0, n_visit = 0, n_tick = 0, n_unused = 0, n_writes = 0;

    chunk_grant_and_donor_select u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    grant_decision_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .item_mon     (item_ch),
        .result_mon   (result_ch),
        .cfg_mon      (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Known values on every input before the first edge
    initial begin
        i_rst_n           = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.opcode    = OP_REQUEST;
        item_ch.worker_id = '0;
        item_ch.was_miss  = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_CHUNK_TOTAL;
        cfg_ch.data       = '0;
        result_ch.ready   = 1'b0;
    end

    // Receiver: random stalls on the result channel, held low during reset
    always @(posedge i_clk) begin
        result_ch.ready <= i_rst_n && ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // One item transfer. Random idle cycles first, then valid is held until
    // ready is seen at an edge. valid only gets one NBA per time step: either
    // lowered for a gap or (re)asserted with the new payload.
    task automatic put(input logic [OP_W-1:0] op, input logic [WID_W-1:0] wid,
                       input logic miss);
        while ($urandom_range(99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= op;
        item_ch.worker_id <= wid;
        item_ch.was_miss  <= miss;
        do @(posedge i_clk); while (!item_ch.ready);
        case (op)
            OP_REQUEST: n_req++;
            OP_VISIT:   n_visit++;
            OP_TICK:    n_tick++;
            default:    n_unused++;
        endcase
    endtask

    // Stop sending and wait for every outstanding result. The extra edge lets
    // the checker's count catch up with a transfer made on the last edge.
    task automatic wait_quiet();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Register write, only ever issued with the block idle
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        wait_quiet();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DATA_W'(value);
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        n_writes++;
    endtask

    initial begin
        int unsigned roll, w;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --------------------------------------------------------------
        // Directed part (sender 34 %, receiver 57 % idle)
        // --------------------------------------------------------------
        put(OP_REQUEST, 4'd0, 1'b0);              // grant at reset settings
        set_reg(CFG_CHUNK_TOTAL, 2);
        put(OP_REQUEST, 4'd15, 1'b0);             // last fresh chunk
        put(OP_REQUEST, 4'd7, 1'b0);              // exhausted, no counts: self
        put(OP_VISIT, 4'd1, 1'b0);
        put(OP_VISIT, 4'd1, 1'b0);                // worker 1 at 100 %
        put(OP_VISIT, 4'd2, 1'b1);                // worker 2 at 0 %
        put(OP_VISIT, 4'd15, 1'b0);
        put(OP_VISIT, 4'd15, 1'b1);               // worker 15 at 50 %
        put(OP_REQUEST, 4'd1, 1'b0);              // best is requester: self
        put(OP_REQUEST, 4'd4, 1'b0);              // donor is worker 1
        put(OP_UNUSED, 4'd9, 1'b1);               // unused opcode
        set_reg(CFG_SPREAD_LIMIT, 100);
        put(OP_REQUEST, 4'd4, 1'b0);              // spread within limit: self
        set_reg(CFG_SPREAD_LIMIT, 0);
        set_reg(CFG_WORKER_COUNT, 0);             // behaves as one worker
        put(OP_REQUEST, 4'd4, 1'b0);
        set_reg(CFG_WORKER_COUNT, 31);            // clamps to all workers
        put(OP_REQUEST, 4'd0, 1'b0);
        put(OP_TICK, 4'd0, 1'b0);                 // every counter to 1
        put(OP_REQUEST, 4'd2, 1'b0);
        put(OP_VISIT, 4'd3, 1'b0);                // worker 3 at 50 % after tick
        put(OP_REQUEST, 4'd8, 1'b0);
        set_reg(CFG_CHUNK_TOTAL, 0);              // below the bump pointer
        put(OP_REQUEST, 4'd5, 1'b0);
        set_reg(CFG_CHUNK_TOTAL, 131071);         // above the chunk store
        put(OP_REQUEST, 4'd6, 1'b0);
        put(OP_REQUEST, 4'd15, 1'b1);
        set_reg(CFG_SPREAD_LIMIT, 127);
        put(OP_REQUEST, 4'd10, 1'b0);

        // --------------------------------------------------------------
        // Random part: one register setting per phase
        // --------------------------------------------------------------
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 2) begin
                src_idle_pct = 34;
                snk_idle_pct = 57;
            end else if (p < 4) begin
                src_idle_pct = 57;
                snk_idle_pct = 34;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            // Mix of partly exhausted, exhausted, clamped and random totals
            case (p)
                0:       set_reg(CFG_CHUNK_TOTAL, $urandom_range(0, 120));
                1:       set_reg(CFG_CHUNK_TOTAL, 0);
                2:       set_reg(CFG_CHUNK_TOTAL, $urandom_range(0, 131071));
                3:       set_reg(CFG_CHUNK_TOTAL, 65536);
                4:       set_reg(CFG_CHUNK_TOTAL, 131071);
                default: set_reg(CFG_CHUNK_TOTAL, $urandom_range(0, 300));
            endcase
            case ($urandom_range(4))
                0:       set_reg(CFG_WORKER_COUNT, 0);
                1:       set_reg(CFG_WORKER_COUNT, 1);
                2:       set_reg(CFG_WORKER_COUNT, 16);
                3:       set_reg(CFG_WORKER_COUNT, 31);
                default: set_reg(CFG_WORKER_COUNT, $urandom_range(0, 31));
            endcase
            case ($urandom_range(5))
                0:       set_reg(CFG_SPREAD_LIMIT, 0);
                1:       set_reg(CFG_SPREAD_LIMIT, 100);
                2:       set_reg(CFG_SPREAD_LIMIT, 127);
                default: set_reg(CFG_SPREAD_LIMIT, $urandom_range(0, 40));
            endcase

            for (int i = 0; i < MAX_WORKERS; i++)
                miss_bias[i] = $urandom_range(0, 100);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Sender holds off until the block has drained completely
                if ((p == 2 && n == ITEMS_PER_PHASE / 2) || $urandom_range(499) == 0)
                    wait_quiet();

                roll = $urandom_range(99);
                w    = $urandom_range(MAX_WORKERS - 1);
                if (roll < 35)
                    put(OP_REQUEST, WID_W'(w), 1'($urandom_range(1)));
                else if (roll < 91)
                    put(OP_VISIT, WID_W'(w), ($urandom_range(99) < miss_bias[w]));
                else if (roll < 94)
                    put(OP_TICK, WID_W'(w), 1'($urandom_range(1)));
                else if (roll < 97)
                    put(OP_UNUSED, WID_W'(w), 1'($urandom_range(1)));
                else
                    put(OP_W'($urandom_range(3)), WID_W'(w), 1'($urandom_range(1)));
            end
        end

        // --------------------------------------------------------------
        // Drain, settle, verdict
        // --------------------------------------------------------------
        wait_quiet();
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Covered %0d requests, %0d visits, %0d ticks, %0d unused opcodes",
                 n_req, n_visit, n_tick, n_unused);
        $display("across %0d register writes, with and without stalls on both sides",
                 n_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cgds_pkg.sv
rtl/cgds_item_if.sv
rtl/cgds_result_if.sv
rtl/cgds_cfg_if.sv
rtl/cgds_front.sv
rtl/cgds_queue.sv
rtl/cgds_back.sv
rtl/chunk_grant_and_donor_select.sv
bench/grant_decision_checker.sv
bench/tb_chunk_grant_and_donor_select.sv
